[hw/rtl/sequenced_height_grid_update_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the height grid update block
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_HEIGHT_GRID_UPDATE_TOP_DEFINES_SVH
`define SEQUENCED_HEIGHT_GRID_UPDATE_TOP_DEFINES_SVH

// same-cycle implication
`define SHGU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHGU_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/shgu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shgu_pkg
// Types and constants shared by the height grid update modules.
// ----------------------------------------------------------------------------
package shgu_pkg;

   localparam int GRID_MAX_SIDE = 256; // cells per side of the height store
   localparam int CFG_W     = 9;   // config register width, also max coordinate width
   localparam int CHUNK_W   = 10;  // signed chunk coordinate width
   localparam int SEQ_W     = 32;
   localparam int FIELD_W   = 16;
   localparam int HEIGHT_W  = 8;
   localparam int DIV_CNT_W = $clog2(CFG_W);

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;

   // status codes; ST_WRITTEN on a queued command means "apply the edit"
   localparam logic [1:0] ST_WRITTEN   = 2'd0;
   localparam logic [1:0] ST_UNCHANGED = 2'd1;
   localparam logic [1:0] ST_SEQ_ERR   = 2'd2;
   localparam logic [1:0] ST_BOUNDS    = 2'd3;

   localparam logic KIND_MARK   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] CSR_GRID_SIDE   = 2'd0;
   localparam logic [1:0] CSR_LAYER_COUNT = 2'd1;
   localparam logic [1:0] CSR_CHUNK_SIDE  = 2'd2;

   typedef struct packed {
      logic [CFG_W-1:0] grid_side;   // already clamped to the grid maximum
      logic [CFG_W-1:0] layer_count;
      logic [CFG_W-1:0] chunk_side;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          code;
      logic [CFG_W-1:0]    x;
      logic [CFG_W-1:0]    z;
      logic [HEIGHT_W-1:0] elev;
   } cmd_type;

   typedef struct packed {
      logic [CFG_W-1:0] quo_x;
      logic [CFG_W-1:0] rem_x;
      logic [CFG_W-1:0] quo_z;
      logic [CFG_W-1:0] rem_z;
   } div_res_type;

endpackage

[hw/rtl/shgu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shgu_front
// Accepts edit words, checks sequence and bounds, clamps the elevation and
// pushes a command into the queue. Owns the last-applied sequence number.
// ----------------------------------------------------------------------------
module shgu_front
   import shgu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  cfg_type               cfg,
   input  logic                  clear_done,
   input  logic                  q_full,
   output logic                  push,
   output cmd_type               push_cmd
);

   logic [SEQ_W-1:0]   last_ff;
   logic [SEQ_W-1:0]   seq;
   logic [FIELD_W-1:0] col;
   logic [FIELD_W-1:0] row;
   logic [FIELD_W-1:0] elev;
   logic               seq_ok;
   logic               zero_cfg;
   logic               in_bounds;
   logic [CFG_W-1:0]   layer_m1;
   logic [HEIGHT_W-1:0] hi;
   logic [HEIGHT_W-1:0] elev_c;

   assign seq  = req_tdata[31:0];
   assign col  = req_tdata[47:32];
   assign row  = req_tdata[63:48];
   assign elev = req_tdata[79:64];

   assign req_tready = clear_done && !q_full;
   assign push       = req_tvalid && req_tready;

   assign seq_ok   = (seq == last_ff + 32'd1);
   assign zero_cfg = (cfg.grid_side == '0) || (cfg.layer_count == '0) ||
                     (cfg.chunk_side == '0);
   assign in_bounds = !col[15] && !row[15] &&
                      (col[14:0] < 15'(cfg.grid_side)) &&
                      (row[14:0] < 15'(cfg.grid_side));

   // clamp ceiling is layer_count - 1, capped at the height width
   assign layer_m1 = cfg.layer_count - 9'd1;
   assign hi       = (layer_m1 > 9'd255) ? 8'hFF : layer_m1[7:0];

   always_comb begin
      if (elev[15]) begin
         elev_c = '0;
      end else if (elev[14:0] > 15'(hi)) begin
         elev_c = hi;
      end else begin
         elev_c = elev[7:0];
      end
   end

   always_comb begin
      push_cmd.x    = col[CFG_W-1:0];
      push_cmd.z    = row[CFG_W-1:0];
      push_cmd.elev = elev_c;
      if (!seq_ok) begin
         push_cmd.code = ST_SEQ_ERR;
      end else if (zero_cfg || !in_bounds) begin
         push_cmd.code = ST_BOUNDS;
      end else begin
         push_cmd.code = ST_WRITTEN;
      end
   end

   // written and unchanged edits both advance the sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (push && push_cmd.code == ST_WRITTEN) begin
         last_ff <= seq;
      end
   end

endmodule

[hw/rtl/shgu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shgu_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module shgu_queue
   import shgu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd,
   output logic    full
);

   cmd_type    slot_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] count_ff;

   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);
   assign head_cmd   = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

[hw/rtl/shgu_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shgu_div
// Restoring serial divider, one quotient bit per cycle, dividing both cell
// coordinates by the chunk side in lockstep.
// ----------------------------------------------------------------------------
module shgu_div
   import shgu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CFG_W-1:0] dividend_x,
   input  logic [CFG_W-1:0] dividend_z,
   input  logic [CFG_W-1:0] divisor,
   output logic             done,
   output div_res_type      res
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [CFG_W-1:0]     d_ff;
   logic [CFG_W-1:0]     qx_ff;
   logic [CFG_W-1:0]     rx_ff;
   logic [CFG_W-1:0]     qz_ff;
   logic [CFG_W-1:0]     rz_ff;

   logic [CFG_W:0]   rx_sh;
   logic [CFG_W:0]   rz_sh;
   logic             x_ge;
   logic             z_ge;
   logic [CFG_W-1:0] rx_in;
   logic [CFG_W-1:0] rz_in;

   assign rx_sh = {rx_ff, qx_ff[CFG_W-1]};
   assign rz_sh = {rz_ff, qz_ff[CFG_W-1]};
   assign x_ge  = (rx_sh >= {1'b0, d_ff});
   assign z_ge  = (rz_sh >= {1'b0, d_ff});
   assign rx_in = x_ge ? CFG_W'(rx_sh - {1'b0, d_ff}) : rx_sh[CFG_W-1:0];
   assign rz_in = z_ge ? CFG_W'(rz_sh - {1'b0, d_ff}) : rz_sh[CFG_W-1:0];

   assign done      = done_ff;
   assign res.quo_x = qx_ff;
   assign res.rem_x = rx_ff;
   assign res.quo_z = qz_ff;
   assign res.rem_z = rz_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         d_ff  <= divisor;
         qx_ff <= dividend_x;
         qz_ff <= dividend_z;
         rx_ff <= '0;
         rz_ff <= '0;
      end else if (busy_ff) begin
         qx_ff <= {qx_ff[CFG_W-2:0], x_ge};
         qz_ff <= {qz_ff[CFG_W-2:0], z_ge};
         rx_ff <= rx_in;
         rz_ff <= rz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(CFG_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

[hw/rtl/shgu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shgu_back
// Clears the height store after reset, then carries out queued commands:
// read, compare, write, divide for chunk coordinates and emit result words.
// ----------------------------------------------------------------------------
module shgu_back
   import shgu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  head_valid,
   input  cmd_type               head_cmd,
   output logic                  pop,
   output logic                  clear_done,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

`include "sequenced_height_grid_update_top_defines.svh"

   localparam int DEPTH  = GRID_MAX_SIDE * GRID_MAX_SIDE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = 2 * CFG_W + 1;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ADDR   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_CMP    = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;
   localparam logic [2:0] S_STATUS = 3'd7;

   logic [HEIGHT_W-1:0] height_mem [DEPTH];

   logic [2:0]          state_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [HEIGHT_W-1:0] rd_ff;
   cmd_type             cur_ff;
   logic [1:0]          status_ff;
   logic [4:0]          mask_ff;   // own, left, right, lower, upper
   logic [CHUNK_W-1:0]  cx_ff;
   logic [CHUNK_W-1:0]  cz_ff;

   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic                rsp_last_ff;
   logic [CHUNK_W-1:0]  rsp_x_ff;
   logic [CHUNK_W-1:0]  rsp_z_ff;
   logic [1:0]          rsp_status_ff;

   logic                out_free;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa;
   logic [HEIGHT_W-1:0] mem_wd;
   logic [IDX_W-1:0]    idx;
   logic                differs;
   logic                div_start;
   logic                div_done;
   div_res_type         div_res;
   logic [CFG_W-1:0]    cs_m1;
   logic [4:0]          pick;
   logic [CHUNK_W-1:0]  mark_x;
   logic [CHUNK_W-1:0]  mark_z;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clear_done = (state_ff != S_CLEAR);
   assign pop        = (state_ff == S_IDLE) && head_valid;
   assign differs    = (rd_ff != cur_ff.elev);
   assign div_start  = (state_ff == S_CMP) && differs;
   assign idx        = IDX_W'(cur_ff.z * cfg.grid_side) + IDX_W'(cur_ff.x);
   assign cs_m1      = cfg.chunk_side - 9'd1;

   assign mem_we = (state_ff == S_CLEAR) || div_start;
   assign mem_wa = (state_ff == S_CLEAR) ? clr_addr_ff : addr_ff;
   assign mem_wd = (state_ff == S_CLEAR) ? '0 : cur_ff.elev;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         height_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= height_mem[addr_ff];
   end

   shgu_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_x (cur_ff.x),
      .dividend_z (cur_ff.z),
      .divisor    (cfg.chunk_side),
      .done       (div_done),
      .res        (div_res)
   );

   // next mark in order: own chunk, left, right, lower, upper
   always_comb begin
      pick   = 5'b00000;
      mark_x = cx_ff;
      mark_z = cz_ff;
      if (mask_ff[0]) begin
         pick = 5'b00001;
      end else if (mask_ff[1]) begin
         pick   = 5'b00010;
         mark_x = cx_ff - 10'd1;
      end else if (mask_ff[2]) begin
         pick   = 5'b00100;
         mark_x = cx_ff + 10'd1;
      end else if (mask_ff[3]) begin
         pick   = 5'b01000;
         mark_z = cz_ff - 10'd1;
      end else if (mask_ff[4]) begin
         pick   = 5'b10000;
         mark_z = cz_ff + 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               cur_ff    <= head_cmd;
               status_ff <= head_cmd.code;
            end
         end
         S_ADDR: begin
            addr_ff <= idx[ADDR_W-1:0];
         end
         S_CMP: begin
            status_ff <= differs ? ST_WRITTEN : ST_UNCHANGED;
         end
         S_DIV: begin
            if (div_done) begin
               cx_ff   <= CHUNK_W'(div_res.quo_x);
               cz_ff   <= CHUNK_W'(div_res.quo_z);
               mask_ff <= {div_res.rem_z == cs_m1, div_res.rem_z == '0,
                           div_res.rem_x == cs_m1, div_res.rem_x == '0, 1'b1};
            end
         end
         S_EMIT: begin
            if (out_free) begin
               mask_ff <= mask_ff & ~pick;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop) begin
                  state_ff <= (head_cmd.code == ST_WRITTEN) ? S_ADDR : S_STATUS;
               end
            end
            S_ADDR:   state_ff <= S_READ;
            S_READ:   state_ff <= S_CMP;
            S_CMP:    state_ff <= differs ? S_DIV : S_STATUS;
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free && (mask_ff & ~pick) == 5'b00000) begin
                  state_ff <= S_STATUS;
               end
            end
            S_STATUS: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free && (state_ff == S_EMIT || state_ff == S_STATUS)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && state_ff == S_EMIT) begin
         rsp_kind_ff   <= KIND_MARK;
         rsp_last_ff   <= 1'b0;
         rsp_x_ff      <= mark_x;
         rsp_z_ff      <= mark_z;
         rsp_status_ff <= ST_WRITTEN;
      end else if (out_free && state_ff == S_STATUS) begin
         rsp_kind_ff   <= KIND_STATUS;
         rsp_last_ff   <= 1'b1;
         rsp_x_ff      <= '0;
         rsp_z_ff      <= '0;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_status_ff, rsp_z_ff, rsp_x_ff};

   `SHGU_ASSERT_IMP(a_pop_in_idle, pop, state_ff == S_IDLE && clear_done, "pop outside idle")
   `SHGU_ASSERT_IMP(a_div_done_waited, div_done, state_ff == S_DIV, "divider done unexpected")
   `SHGU_ASSERT_IMP(a_mem_we_state, mem_we, state_ff == S_CMP || state_ff == S_CLEAR, "stray write")
   `SHGU_ASSERT_IMP(a_last_is_status, rsp_tvalid && rsp_tlast, rsp_tuser == KIND_STATUS, "bad last")
   `SHGU_ASSERT_NXT(a_status_ends, state_ff == S_STATUS && out_free, state_ff == S_IDLE, "no idle")

endmodule

[hw/rtl/sequenced_height_grid_update_top.sv]
`timescale 1ns / 1ps
// Usage:
// req_ carries one edit word per handshake: sequence number, column, row and
// elevation. rsp_ returns zero to five dirty chunk marks (tuser = 0) followed
// by one status word (tuser = 1, tlast = 1) for every edit, in edit order.
// csr_ writes grid_side, layer_count and chunk_side; write only while idle.
// Flow: a rejected edit goes from the queue straight to its status word; an
// unchanged one first passes the address, read and compare states. An applied
// edit then enters the serial chunk divider (one quotient bit per cycle) and
// emits its marks before its status word.
// The back end handles one edit at a time; a two-entry queue lets the front
// take up to two more edits while it works.
// Reset: the height store is cleared one cell per cycle, all GRID_MAX_SIDE^2
// cells (65536 at the default); req_tready stays low until that finishes.
// Config registers and the sequence number return to their reset values.
// A stalled rsp_tready holds the current word in the output register and
// backs up the queue, then req_tready.
// ----------------------------------------------------------------------------
// sequenced_height_grid_update_top
// Sequenced height grid editor with dirty chunk marking.
// ----------------------------------------------------------------------------
module sequenced_height_grid_update_top
   import shgu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // sequence_number[31:0], column[47:32], row[63:48], elevation[79:64]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // chunk_x[9:0], chunk_z[19:10], status[21:20], zero pad[23:22]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // result_kind[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic [CFG_W-1:0] grid_side_ff;
   logic [CFG_W-1:0] layer_count_ff;
   logic [CFG_W-1:0] chunk_side_ff;
   cfg_type          cfg;
   logic             clear_done;
   logic             q_full;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   logic             head_valid;
   cmd_type          head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff   <= 9'd256;
         layer_count_ff <= 9'd256;
         chunk_side_ff  <= 9'd16;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_SIDE:   grid_side_ff   <= csr_wdata;
            CSR_LAYER_COUNT: layer_count_ff <= csr_wdata;
            CSR_CHUNK_SIDE:  chunk_side_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // grid side beyond the store acts as the store side
   assign cfg.grid_side   = (32'(grid_side_ff) > 32'(GRID_MAX_SIDE)) ?
                            CFG_W'(GRID_MAX_SIDE) : grid_side_ff;
   assign cfg.layer_count = layer_count_ff;
   assign cfg.chunk_side  = chunk_side_ff;

   shgu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .clear_done (clear_done),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   shgu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (q_full)
   );

   shgu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .clear_done (clear_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
